// File: rtl/run_length_clut_line_decoder_defines.svh
// assertion macros shared by the line decoder modules
`ifndef RUN_LENGTH_CLUT_LINE_DECODER_DEFINES_SVH
`define RUN_LENGTH_CLUT_LINE_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RLCD_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("rlcd assertion failed");

// next-cycle implication, checked outside reset
`define RLCD_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("rlcd assertion failed");

`endif

// File: rtl/rlcd_pkg.sv
// shared constants, types and helpers of the run-length line decoder
`default_nettype none

package rlcd_pkg;

  localparam int MAX_LINE_WIDTH = 768;
  localparam int TABLE_DEPTH    = 256;
  localparam int TBL_AW         = $clog2(TABLE_DEPTH);

  localparam int POS_W      = 10;
  localparam int WIDE_W     = POS_W + 1;
  localparam int BYTE_W     = 8;
  localparam int COLOR_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [WIDE_W-1:0] MAX_WIDTH_W  = WIDE_W'(MAX_LINE_WIDTH);
  localparam logic [POS_W-1:0]  LINE_WIDTH_RESET = POS_W'(384);
  localparam logic [BYTE_W:0]   DEPTH_W9     = (BYTE_W + 1)'(TABLE_DEPTH);
  localparam logic [BYTE_W-1:0] BANK_OFFSET  = 8'h80;
  localparam int                HDR_REPEAT_BIT = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BANK = 2'd2;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_TABLE = 1'b1;

  typedef struct packed {
    logic              wr_en;
    logic [TBL_AW-1:0] wr_addr;
    logic              rd_en;
    logic [TBL_AW-1:0] rd_addr_a;
    logic [TBL_AW-1:0] rd_addr_b;
  } clut_req_t;

  typedef struct packed {
    logic [POS_W-1:0] start_x;
    logic [POS_W-1:0] pixel_count;
    logic             line_end;
  } run_info_t;

  // colour index plus bank offset, wrapped to the table depth
  function automatic logic [TBL_AW-1:0] clut_addr(input logic [6:0] idx, input logic bank);
    logic [BYTE_W:0] sum;
    sum = {2'b00, idx} + (bank ? {1'b0, BANK_OFFSET} : 9'd0);
    if (sum >= DEPTH_W9) begin
      sum = sum - DEPTH_W9;
    end
    return sum[TBL_AW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/rlcd_clut.sv
// colour lookup table: one write port, two registered read ports
`default_nettype none

module rlcd_clut (
  input  wire logic                          clk,
  input  wire rlcd_pkg::clut_req_t           req,
  input  wire logic [rlcd_pkg::COLOR_W-1:0]  wr_data,
  output logic      [rlcd_pkg::COLOR_W-1:0]  rd_data_a,
  output logic      [rlcd_pkg::COLOR_W-1:0]  rd_data_b
);

  logic [rlcd_pkg::COLOR_W-1:0] mem [rlcd_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
  end

  // read data holds while no new run is issued
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_a <= mem[req.rd_addr_a];
      rd_data_b <= mem[req.rd_addr_b];
    end
  end

endmodule

`default_nettype wire

// File: rtl/rlcd_ctrl.sv
// config registers, line state and run decode feeding the lookup stage
`default_nettype none

`include "run_length_clut_line_decoder_defines.svh"

module rlcd_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [rlcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rlcd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             accept,
  input  wire logic                             op,
  input  wire logic [rlcd_pkg::BYTE_W-1:0]      data_byte,
  input  wire logic [rlcd_pkg::BYTE_W-1:0]      table_index,
  input  wire logic                             advance,
  output rlcd_pkg::clut_req_t                   clut_req,
  output logic                                  run_pend,
  output rlcd_pkg::run_info_t                   run_meta
);

  logic                          pair_mode;
  logic [rlcd_pkg::POS_W-1:0]    line_width;
  logic                          upper_bank;

  logic [rlcd_pkg::POS_W-1:0]    line_position;
  logic [rlcd_pkg::POS_W-1:0]    line_position_next;
  logic [rlcd_pkg::BYTE_W-1:0]   held_header;
  logic                          awaiting_count;

  logic                          is_data;
  logic                          run_go;
  logic [rlcd_pkg::BYTE_W-1:0]   header;
  logic [rlcd_pkg::BYTE_W-1:0]   count;
  logic [rlcd_pkg::WIDE_W-1:0]   width_eff;
  logic [rlcd_pkg::WIDE_W-1:0]   pos;
  logic [rlcd_pkg::WIDE_W-1:0]   remaining;
  logic [rlcd_pkg::WIDE_W-1:0]   n_raw;
  logic [rlcd_pkg::WIDE_W-1:0]   n;
  logic [rlcd_pkg::WIDE_W-1:0]   end_pos;
  logic                          line_end;
  logic [6:0]                    idx_a;
  logic [6:0]                    idx_b;
  logic                          pos_matches_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_mode  <= 1'b0;
      line_width <= rlcd_pkg::LINE_WIDTH_RESET;
      upper_bank <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlcd_pkg::CFG_PAIR_MODE:  pair_mode  <= cfg_data[0];
        rlcd_pkg::CFG_LINE_WIDTH: line_width <= cfg_data[rlcd_pkg::POS_W-1:0];
        rlcd_pkg::CFG_UPPER_BANK: upper_bank <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    is_data = accept && (op == rlcd_pkg::OP_DATA);
    run_go  = is_data && (awaiting_count || !data_byte[rlcd_pkg::HDR_REPEAT_BIT]);
    header  = awaiting_count ? held_header : data_byte;
    count   = awaiting_count ? data_byte : 8'd1;

    // zero acts as one, oversize clamps to the line maximum
    if (line_width == '0) begin
      width_eff = rlcd_pkg::WIDE_W'(1);
    end else if ({1'b0, line_width} > rlcd_pkg::MAX_WIDTH_W) begin
      width_eff = rlcd_pkg::MAX_WIDTH_W;
    end else begin
      width_eff = {1'b0, line_width};
    end

    // a position past a shrunk width restarts the line
    pos       = ({1'b0, line_position} >= width_eff) ? '0 : {1'b0, line_position};
    remaining = width_eff - pos;

    n_raw = pair_mode ? rlcd_pkg::WIDE_W'({count, 1'b0}) : rlcd_pkg::WIDE_W'(count);
    n     = ((count == '0) || (n_raw > remaining)) ? remaining : n_raw;

    end_pos            = pos + n;
    line_end           = (end_pos >= width_eff);
    line_position_next = line_end ? '0 : end_pos[rlcd_pkg::POS_W-1:0];

    idx_a = pair_mode ? {4'b0000, header[6:4]} : header[6:0];
    idx_b = pair_mode ? {4'b0000, header[2:0]} : header[6:0];

    clut_req.wr_en     = accept && (op == rlcd_pkg::OP_TABLE) &&
                         ({1'b0, table_index} < rlcd_pkg::DEPTH_W9);
    clut_req.wr_addr   = table_index[rlcd_pkg::TBL_AW-1:0];
    clut_req.rd_en     = run_go;
    clut_req.rd_addr_a = rlcd_pkg::clut_addr(idx_a, upper_bank);
    clut_req.rd_addr_b = rlcd_pkg::clut_addr(idx_b, upper_bank);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_position  <= '0;
      held_header    <= '0;
      awaiting_count <= 1'b0;
    end else if (is_data) begin
      if (awaiting_count) begin
        awaiting_count <= 1'b0;
        line_position  <= line_position_next;
      end else if (data_byte[rlcd_pkg::HDR_REPEAT_BIT]) begin
        held_header    <= data_byte;
        awaiting_count <= 1'b1;
      end else begin
        line_position  <= line_position_next;
      end
    end
  end

  // run waiting for its colours to come out of the table
  always_ff @(posedge clk) begin
    if (rst) begin
      run_pend <= 1'b0;
    end else if (run_go) begin
      run_pend <= 1'b1;
    end else if (advance) begin
      run_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (run_go) begin
      run_meta.start_x     <= pos[rlcd_pkg::POS_W-1:0];
      run_meta.pixel_count <= n[rlcd_pkg::POS_W-1:0];
      run_meta.line_end    <= line_end;
    end
  end

  // position after a run is its end, or zero once the line is done
  assign pos_matches_run = run_meta.line_end ? (line_position == '0) :
      ({1'b0, line_position} == ({1'b0, run_meta.start_x} + {1'b0, run_meta.pixel_count}));

  `RLCD_ASSERT_IMPL(a_header_has_repeat, clk, rst, awaiting_count, held_header[rlcd_pkg::HDR_REPEAT_BIT])
  `RLCD_ASSERT_NEXT(a_position_follows_run, clk, rst, run_go, pos_matches_run)

endmodule

`default_nettype wire

// File: rtl/run_length_clut_line_decoder.sv
// top level: byte channel, table lookup stage and run output register
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------------------
//  bytes    | byte_valid/byte_stall | op, data_byte, table_index, table_color
//  runs     | run_valid/run_stall   | first_rgb, second_rgb, start_x, pixel_count, line_end
//  config   | cfg_we                | cfg_index, cfg_data
//
// one beat per cycle on the byte channel while byte_stall is low
// the run decode and table read happen in the accepting cycle; the colours land in the colour table's
// registered read ports and are copied into the output register once the output can advance
// reset clears line position, pending count and valids; the table content is not cleared
// a stalled run output stalls bytes only once the lookup stage behind it is also full

`default_nettype none

`include "run_length_clut_line_decoder_defines.svh"

module run_length_clut_line_decoder (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [rlcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rlcd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             byte_valid,
  output logic                                  byte_stall,
  input  wire logic                             op,
  input  wire logic [rlcd_pkg::BYTE_W-1:0]      data_byte,
  input  wire logic [rlcd_pkg::BYTE_W-1:0]      table_index,
  input  wire logic [rlcd_pkg::COLOR_W-1:0]     table_color,
  output logic                                  run_valid,
  input  wire logic                             run_stall,
  output logic      [rlcd_pkg::COLOR_W-1:0]     first_rgb,
  output logic      [rlcd_pkg::COLOR_W-1:0]     second_rgb,
  output logic      [rlcd_pkg::POS_W-1:0]       start_x,
  output logic      [rlcd_pkg::POS_W-1:0]       pixel_count,
  output logic                                  line_end
);

  rlcd_pkg::clut_req_t           clut_req;
  rlcd_pkg::run_info_t           run_meta;
  logic                          run_pend;
  logic                          advance;
  logic                          byte_accept;
  logic [rlcd_pkg::COLOR_W-1:0]  rd_data_a;
  logic [rlcd_pkg::COLOR_W-1:0]  rd_data_b;
  logic [rlcd_pkg::WIDE_W-1:0]   run_end_x;

  assign advance     = !run_valid || !run_stall;
  assign byte_stall  = run_pend && !advance;
  assign byte_accept = byte_valid && !byte_stall;

  rlcd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (byte_accept),
    .op          (op),
    .data_byte   (data_byte),
    .table_index (table_index),
    .advance     (advance),
    .clut_req    (clut_req),
    .run_pend    (run_pend),
    .run_meta    (run_meta)
  );

  rlcd_clut u_clut (
    .clk       (clk),
    .req       (clut_req),
    .wr_data   (table_color),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
    end else if (advance) begin
      run_valid <= run_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && run_pend) begin
      first_rgb   <= rd_data_a;
      second_rgb  <= rd_data_b;
      start_x     <= run_meta.start_x;
      pixel_count <= run_meta.pixel_count;
      line_end    <= run_meta.line_end;
    end
  end

  assign run_end_x = {1'b0, start_x} + {1'b0, pixel_count};

  `RLCD_ASSERT_IMPL(a_stall_needs_full_output, clk, rst, byte_stall, (run_valid && run_stall && run_pend))
  `RLCD_ASSERT_IMPL(a_run_not_empty, clk, rst, run_valid, (pixel_count != '0))
  `RLCD_ASSERT_IMPL(a_run_within_line, clk, rst, run_valid, (run_end_x <= rlcd_pkg::MAX_WIDTH_W))

endmodule

`default_nettype wire
